[sv/sll_pkg.sv]
`timescale 1ns / 1ps
// Package for the shell line lexer: result beat type, token kinds, byte codes
// and byte classification helpers. Depends on nothing.
package sll_pkg;

    typedef logic [3:0] kind_t;

    localparam kind_t KIND_IDENT   = 4'd0;
    localparam kind_t KIND_LABEL   = 4'd1;
    localparam kind_t KIND_NUMBER  = 4'd2;
    localparam kind_t KIND_STRING  = 4'd3;
    localparam kind_t KIND_LPAREN  = 4'd4;
    localparam kind_t KIND_RPAREN  = 4'd5;
    localparam kind_t KIND_COMMA   = 4'd6;
    localparam kind_t KIND_DOT     = 4'd7;
    localparam kind_t KIND_EQUAL   = 4'd8;
    localparam kind_t KIND_PIPE    = 4'd9;
    localparam kind_t KIND_LESS    = 4'd10;
    localparam kind_t KIND_GREATER = 4'd11;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_GREATER = 8'h3E;

    // One result beat.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic       cv;
        logic       st;
        logic       en;
        logic       lst;
    } item_t;

    // Operator kind of a byte, or KIND_IDENT when it is no operator.
    function automatic kind_t op_kind(logic [7:0] c);
        kind_t k;
        unique case (c)
            CH_LPAREN:  k = KIND_LPAREN;
            CH_RPAREN:  k = KIND_RPAREN;
            CH_COMMA:   k = KIND_COMMA;
            CH_DOT:     k = KIND_DOT;
            CH_EQUAL:   k = KIND_EQUAL;
            CH_PIPE:    k = KIND_PIPE;
            CH_LESS:    k = KIND_LESS;
            CH_GREATER: k = KIND_GREATER;
            default:    k = KIND_IDENT;
        endcase
        return k;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

[sv/shell_line_lexer_unit.sv]
`timescale 1ns / 1ps
// Shell line lexer top level: input register, lexer step logic and a result queue.
// Depends on sll_pkg.
// A byte passes through the input register, and its result beats are offered from the result queue.
// Input: one beat per cycle while the result queue has room for two beats; a byte that
// yields two results uses the single output port twice, so that port sets the sustained rate.
// Reset clears the lexer state and empties the input register and the result queue.
module shell_line_lexer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_char,
    input  logic       char_valid,
    input  logic       line_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] token_kind_out,
    output logic [7:0] out_char,
    output logic       out_char_valid,
    output logic       token_start,
    output logic       token_end,
    output logic       last
);

    typedef enum logic [2:0] {
        MODE_WS,
        MODE_IDENT,
        MODE_NUM,
        MODE_STR,
        MODE_COMMENT
    } mode_t;

    typedef struct packed {
        sll_pkg::item_t it0;
        sll_pkg::item_t it1;
        logic [1:0]     cnt;
    } emit_list_t;

    // Appends a beat; a third beat can never occur for one byte.
    function automatic emit_list_t push(emit_list_t l, sll_pkg::item_t x);
        emit_list_t r;
        r = l;
        if (l.cnt == 2'd0)
        begin
            r.it0 = x;
            r.cnt = 2'd1;
        end
        else if (l.cnt == 2'd1)
        begin
            r.it1 = x;
            r.cnt = 2'd2;
        end
        return r;
    endfunction

    function automatic sll_pkg::item_t mk_item(sll_pkg::kind_t k, logic [7:0] c, logic cv,
                                               logic st, logic en);
        sll_pkg::item_t x;
        x.kind = k;
        x.ch   = cv ? c : 8'd0;
        x.cv   = cv;
        x.st   = st;
        x.en   = en;
        x.lst  = 1'b0;
        return x;
    endfunction

    // Input register.
    logic       in_full_reg, in_full_next;
    logic [7:0] in_char_reg;
    logic       in_cv_reg;
    logic       in_le_reg;

    // Lexer state.
    mode_t          mode_reg, mode_next;
    logic           esc_reg, esc_next;
    sll_pkg::kind_t kind_reg, kind_next;
    logic           begun_reg, begun_next;

    // Result queue.
    sll_pkg::item_t fifo_reg [4];
    logic [1:0]     wr_ptr_reg, wr_ptr_next;
    logic [1:0]     rd_ptr_reg, rd_ptr_next;
    logic [2:0]     count_reg, count_next;

    logic           can_take;
    logic           do_step;
    logic           in_accept;
    logic           out_pop;
    emit_list_t     list;
    logic           open_c;
    logic [7:0]     c;
    logic [7:0]     esc_c;
    sll_pkg::kind_t opk;
    logic           sp;
    logic           dig;

    // Room for two beats is needed before a byte is worked on.
    assign can_take  = (count_reg <= 3'd2);
    assign do_step   = in_full_reg && can_take;
    assign in_stall  = in_full_reg && !can_take;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = (count_reg != 3'd0);
    assign out_pop   = out_valid && !out_stall;

    assign c   = in_char_reg;
    assign opk = sll_pkg::op_kind(in_char_reg);
    assign sp  = sll_pkg::is_space(in_char_reg);
    assign dig = sll_pkg::is_digit(in_char_reg);

    always_comb
    begin
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        kind_next  = kind_reg;
        begun_next = begun_reg;
        list       = '0;
        open_c     = 1'b0;
        esc_c      = c;

        if (do_step && in_cv_reg)
        begin
            unique case (mode_reg) inside
                MODE_IDENT, MODE_NUM:
                begin
                    if ((mode_reg == MODE_IDENT && (dig || (opk == sll_pkg::KIND_IDENT && !sp &&
                            c != sll_pkg::CH_QUOTE && c != sll_pkg::CH_HASH))) ||
                        (mode_reg == MODE_NUM && (dig || c == sll_pkg::CH_DOT)))
                    begin
                        list = push(list, mk_item(kind_reg, c, 1'b1, !begun_reg, 1'b0));
                        begun_next = 1'b1;
                        open_c = 1'b1;
                    end
                    else
                    begin
                        // Close the word, then treat the byte as in whitespace.
                        list = push(list, mk_item(kind_reg, 8'd0, 1'b0, !begun_reg, 1'b1));
                        begun_next = 1'b0;
                        mode_next = MODE_WS;
                        if (c == sll_pkg::CH_QUOTE)
                        begin
                            mode_next = MODE_STR;
                            kind_next = sll_pkg::KIND_STRING;
                            esc_next  = 1'b0;
                        end
                        else if (c == sll_pkg::CH_HASH)
                        begin
                            mode_next = MODE_COMMENT;
                        end
                        else if (opk != sll_pkg::KIND_IDENT)
                        begin
                            list = push(list, mk_item(opk, c, 1'b1, 1'b1, 1'b1));
                        end
                        else if (!sp)
                        begin
                            mode_next = MODE_IDENT;
                            kind_next = (c == sll_pkg::CH_DASH) ? sll_pkg::KIND_LABEL
                                                                : sll_pkg::KIND_IDENT;
                            esc_next  = 1'b0;
                            list = push(list, mk_item(kind_next, c, 1'b1, 1'b1, 1'b0));
                            begun_next = 1'b1;
                            open_c = 1'b1;
                        end
                    end
                end
                MODE_STR:
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        if (c == sll_pkg::CH_N)
                            esc_c = sll_pkg::CH_LF;
                        else if (c == sll_pkg::CH_R)
                            esc_c = sll_pkg::CH_CR;
                        else if (c == sll_pkg::CH_T)
                            esc_c = sll_pkg::CH_TAB;
                        list = push(list, mk_item(kind_reg, esc_c, 1'b1, !begun_reg, 1'b0));
                        begun_next = 1'b1;
                        open_c = 1'b1;
                    end
                    else if (c == sll_pkg::CH_BSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (c == sll_pkg::CH_QUOTE)
                    begin
                        list = push(list, mk_item(kind_reg, 8'd0, 1'b0, !begun_reg, 1'b1));
                        begun_next = 1'b0;
                        mode_next = MODE_WS;
                    end
                    else
                    begin
                        list = push(list, mk_item(kind_reg, c, 1'b1, !begun_reg, 1'b0));
                        begun_next = 1'b1;
                        open_c = 1'b1;
                    end
                end
                MODE_COMMENT:
                begin
                end
                default:
                begin
                    mode_next = MODE_WS;
                    if (c == sll_pkg::CH_QUOTE)
                    begin
                        mode_next  = MODE_STR;
                        kind_next  = sll_pkg::KIND_STRING;
                        begun_next = 1'b0;
                        esc_next   = 1'b0;
                    end
                    else if (dig)
                    begin
                        mode_next = MODE_NUM;
                        kind_next = sll_pkg::KIND_NUMBER;
                        esc_next  = 1'b0;
                        list = push(list, mk_item(sll_pkg::KIND_NUMBER, c, 1'b1, 1'b1, 1'b0));
                        begun_next = 1'b1;
                        open_c = 1'b1;
                    end
                    else if (c == sll_pkg::CH_HASH)
                    begin
                        mode_next = MODE_COMMENT;
                    end
                    else if (opk != sll_pkg::KIND_IDENT)
                    begin
                        list = push(list, mk_item(opk, c, 1'b1, 1'b1, 1'b1));
                    end
                    else if (!sp)
                    begin
                        mode_next = MODE_IDENT;
                        kind_next = (c == sll_pkg::CH_DASH) ? sll_pkg::KIND_LABEL
                                                            : sll_pkg::KIND_IDENT;
                        esc_next  = 1'b0;
                        list = push(list, mk_item(kind_next, c, 1'b1, 1'b1, 1'b0));
                        begun_next = 1'b1;
                        open_c = 1'b1;
                    end
                end
            endcase
        end

        if (do_step && in_le_reg)
        begin
            if (mode_next == MODE_IDENT || mode_next == MODE_NUM || mode_next == MODE_STR)
            begin
                // A character just added carries the end mark itself.
                if (open_c && list.cnt == 2'd1)
                    list.it0.en = 1'b1;
                else if (open_c && list.cnt == 2'd2)
                    list.it1.en = 1'b1;
                else
                    list = push(list, mk_item(kind_next, 8'd0, 1'b0, !begun_next, 1'b1));
            end
            mode_next  = MODE_WS;
            esc_next   = 1'b0;
            begun_next = 1'b0;
        end

        if (list.cnt == 2'd1)
            list.it0.lst = 1'b1;
        else if (list.cnt == 2'd2)
            list.it1.lst = 1'b1;
    end

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_accept)
            in_full_next = 1'b1;
        else if (do_step)
            in_full_next = 1'b0;

        wr_ptr_next = wr_ptr_reg + {1'b0, list.cnt != 2'd0} + {1'b0, list.cnt == 2'd2};
        rd_ptr_next = rd_ptr_reg + {1'b0, out_pop};
        count_next  = count_reg + {1'b0, list.cnt} - {2'b00, out_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            mode_reg    <= MODE_WS;
            esc_reg     <= 1'b0;
            kind_reg    <= sll_pkg::KIND_IDENT;
            begun_reg   <= 1'b0;
            wr_ptr_reg  <= 2'd0;
            rd_ptr_reg  <= 2'd0;
            count_reg   <= 3'd0;
        end
        else
        begin
            in_full_reg <= in_full_next;
            mode_reg    <= mode_next;
            esc_reg     <= esc_next;
            kind_reg    <= kind_next;
            begun_reg   <= begun_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_char_reg <= text_char;
            in_cv_reg   <= char_valid;
            in_le_reg   <= line_end;
        end
        if (list.cnt != 2'd0)
            fifo_reg[wr_ptr_reg] <= list.it0;
        if (list.cnt == 2'd2)
            fifo_reg[wr_ptr_reg + 2'd1] <= list.it1;
    end

    assign token_kind_out = fifo_reg[rd_ptr_reg].kind;
    assign out_char       = fifo_reg[rd_ptr_reg].ch;
    assign out_char_valid = fifo_reg[rd_ptr_reg].cv;
    assign token_start    = fifo_reg[rd_ptr_reg].st;
    assign token_end      = fifo_reg[rd_ptr_reg].en;
    assign last           = fifo_reg[rd_ptr_reg].lst;

endmodule
